FILE: rtl/text_terminal_char_writer_assert.svh
// Assertion macros used by the checker file of the terminal writer.
// No dependencies; include after the module header.
`ifndef TEXT_TERMINAL_CHAR_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TTCW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TTCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ttcw_pkg.sv
// Types and constants of the text terminal writer.
// No dependencies; compile first.
`default_nettype none

package ttcw_pkg;

   localparam logic [7:0] CH_BLANK = 8'h20;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam int REQ_W  = 24;
   localparam int RSP_W  = 88;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 12;

   typedef enum logic [1:0] {
      K_READ,
      K_BACK,
      K_NEWLINE,
      K_PRINT
   } kind_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_CHAR_WIDTH  = 2'd0,
      REG_CHAR_HEIGHT = 2'd1,
      REG_X_SCROLL    = 2'd2,
      REG_Y_SCROLL    = 2'd3
   } reg_index_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_in;
      logic [6:0] read_col;
      logic [4:0] read_row;
      logic       read_ok;
      logic       end_of_buffer;
   } item_type;

   typedef struct packed {
      logic [7:0]  char_width;
      logic [7:0]  char_height;
      logic [11:0] x_scroll_offset;
      logic [11:0] y_scroll_offset;
   } cfg_type;

   typedef struct packed {
      logic        rect_valid;
      logic        full_redraw;
      logic [15:0] rect_left;
      logic [15:0] rect_right;
      logic [15:0] rect_top;
      logic [15:0] rect_bottom;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [7:0]  read_char;
      logic        buffer_done;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/text_terminal_char_writer.sv
// Top level of the character-cell terminal writer: ports, settings, wiring.
// Depends on ttcw_pkg, ttcw_front, ttcw_fifo and ttcw_back.
//
//   channel  role        handshake              content
//   req_     write/read  req_tvalid/req_tready  byte, read cell, end of buffer
//   rsp_     result      rsp_tvalid/rsp_tready  redraw rectangle, cursor, cell
//   csr_     settings    csr_we                 cell size, scroll offsets
//
// In the back-end sequencer an item is executed, then its result register is
// loaded; the next item is taken in the cycle the result loads.
// A new line on the last row blanks the new bottom row before the result loads,
// through the single write port of the screen store.
// After reset all COLS*ROWS cells (1920 by default) are swept to spaces,
// with req_tready low; settings writes are taken throughout.
// A stalled result holds in its register while up to two items queue.
`default_nettype none

module text_terminal_char_writer
   import ttcw_pkg::*;
#(
   parameter int COLS = 80,
   parameter int ROWS = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // byte_in[7:0], read_col[14:8], read_row[19:15], zero pad
   input  wire logic [REQ_W-1:0]  req_tdata,
   // cmd
   input  wire logic              req_tuser,
   input  wire logic              req_tlast,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // rect_left, rect_right, rect_top, rect_bottom, cursor_col[70:64],
   // cursor_row[75:71], read_char[83:76], zero pad
   output logic [RSP_W-1:0]       rsp_tdata,
   // rect_valid[0], full_redraw[1]
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   localparam int QUEUE_DEPTH = 2;

   cfg_type    cfg_ff, cfg_in;
   item_type   push_item, pop_item;
   logic       push_valid, push_ready;
   logic       pop_valid, pop_ready;
   logic       init_busy;
   result_type result;

   // settings: write the addressed register, leave the rest
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_CHAR_WIDTH:  cfg_in.char_width      = csr_wdata[7:0];
            REG_CHAR_HEIGHT: cfg_in.char_height     = csr_wdata[7:0];
            REG_X_SCROLL:    cfg_in.x_scroll_offset = csr_wdata;
            REG_Y_SCROLL:    cfg_in.y_scroll_offset = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.char_width      <= 8'd8;
         cfg_ff.char_height     <= 8'd16;
         cfg_ff.x_scroll_offset <= '0;
         cfg_ff.y_scroll_offset <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify incoming beats
   ttcw_front #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .init_busy  (init_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouple front from back
   ttcw_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // execute against cursor and screen store
   ttcw_back #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .init_busy (init_busy),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (result)
   );

   // pack the result beat
   assign rsp_tdata = {4'b0, result.read_char, result.cursor_row, result.cursor_col,
                       result.rect_bottom, result.rect_top, result.rect_right,
                       result.rect_left};
   assign rsp_tuser = {result.full_redraw, result.rect_valid};
   assign rsp_tlast = result.buffer_done;

endmodule

`default_nettype wire

FILE: rtl/ttcw_front.sv
// Front end: unpacks request beats and classifies them for the back end.
// Depends on ttcw_pkg.
`default_nettype none

module ttcw_front
   import ttcw_pkg::*;
#(
   parameter int COLS = 80,
   parameter int ROWS = 24
) (
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             req_tuser,
   input  wire logic             req_tlast,
   input  wire logic             init_busy,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output item_type              push_item
);

   logic [7:0] byte_w;
   logic [6:0] col_w;
   logic [4:0] row_w;

   assign byte_w = req_tdata[7:0];
   assign col_w  = req_tdata[14:8];
   assign row_w  = req_tdata[19:15];

   // hold off requests while the screen is being cleared after reset
   assign req_tready = push_ready && !init_busy;
   assign push_valid = req_tvalid && !init_busy;

   always_comb begin
      push_item.byte_in       = byte_w;
      push_item.read_col      = col_w;
      push_item.read_row      = row_w;
      push_item.end_of_buffer = req_tlast;
      push_item.read_ok       = (32'(col_w) < COLS) && (32'(row_w) < ROWS);
      if (req_tuser) begin
         push_item.kind = K_READ;
      end else begin
         unique case (byte_w) inside
            CH_BS:        push_item.kind = K_BACK;
            CH_CR, CH_LF: push_item.kind = K_NEWLINE;
            default:      push_item.kind = K_PRINT;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ttcw_fifo.sv
// Short queue of classified items between front and back end.
// Depends on ttcw_pkg.
`default_nettype none

module ttcw_fifo
   import ttcw_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output logic          push_ready,
   input  wire item_type push_item,
   output logic          pop_valid,
   input  wire logic     pop_ready,
   output item_type      pop_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   item_type        slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ttcw_back.sv
// Back end: cursor, screen store, scroll clearing and result register.
// Depends on ttcw_pkg.
`default_nettype none

module ttcw_back
   import ttcw_pkg::*;
#(
   parameter int COLS = 80,
   parameter int ROWS = 24
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     pop_valid,
   output logic          pop_ready,
   input  wire item_type pop_item,
   output logic          init_busy,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output result_type    rsp
);

   localparam int TOTAL = COLS * ROWS;
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam int AW    = $clog2(TOTAL);
   localparam int RSW   = ((RW > 5) ? RW : 5) + 1;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_FINISH
   } state_type;

   state_type     state_ff, state_in;
   item_type      item_ff, item_in;
   logic [RW-1:0] rphys_ff, rphys_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] line_ff, line_in;
   logic [RW-1:0] top_ff, top_in;
   logic [RW-1:0] phys_ff, phys_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] clr_last_ff, clr_last_in;
   logic          pend_ff, pend_in;
   logic [15:0]   mulx_ff, mulx_in;
   logic [15:0]   muly_ff, muly_in;
   logic          rect_ff, rect_in;
   logic          full_ff, full_in;
   logic          out_valid_ff, out_valid_in;
   result_type    out_ff, out_in;

   logic [7:0]    mem [TOTAL];
   logic [7:0]    mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;

   logic [RSW-1:0] rsum;
   logic [RW-1:0]  rphys_calc;
   logic [CW-1:0]  col_dec;
   logic [AW-1:0]  base_next;
   logic           nl;
   logic [15:0]    left_w, top_w;
   result_type     result_now;

   assign init_busy = (state_ff == S_CLEAR) && !pend_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // visible row of a read, rotated onto its physical row
   assign rsum       = RSW'(top_ff) + RSW'(pop_item.read_row);
   assign rphys_calc = (rsum >= RSW'(ROWS)) ? RW'(rsum - RSW'(ROWS)) : RW'(rsum);
   assign mem_raddr  = AW'(32'(rphys_ff) * COLS) + AW'(item_ff.read_col);

   assign col_dec   = col_ff - CW'(1);
   assign base_next = (phys_ff == RW'(ROWS - 1)) ? '0 : base_ff + AW'(COLS);

   assign left_w = mulx_ff - 16'(cfg.x_scroll_offset);
   assign top_w  = muly_ff - 16'(cfg.y_scroll_offset);

   always_comb begin
      result_now.rect_valid  = rect_ff;
      result_now.full_redraw = full_ff;
      result_now.rect_left   = rect_ff ? left_w : '0;
      result_now.rect_right  = rect_ff ? left_w + 16'(cfg.char_width) : '0;
      result_now.rect_top    = rect_ff ? top_w : '0;
      result_now.rect_bottom = rect_ff ? top_w + 16'(cfg.char_height) : '0;
      result_now.cursor_col  = 7'(col_ff);
      result_now.cursor_row  = 5'(line_ff);
      result_now.read_char   = (item_ff.kind == K_READ && item_ff.read_ok) ?
                               mem_rdata_ff : '0;
      result_now.buffer_done = item_ff.end_of_buffer;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rphys_in     = rphys_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      top_in       = top_ff;
      phys_in      = phys_ff;
      base_in      = base_ff;
      clr_addr_in  = clr_addr_ff;
      clr_last_in  = clr_last_ff;
      pend_in      = pend_ff;
      mulx_in      = mulx_ff;
      muly_in      = muly_ff;
      rect_in      = rect_ff;
      full_in      = full_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      mem_we       = 1'b0;
      mem_waddr    = base_ff + AW'(col_ff);
      mem_wdata    = item_ff.byte_in;
      pop_ready    = 1'b0;
      nl           = 1'b0;

      // drop the result once it is taken
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = CH_BLANK;
            if (clr_addr_ff == clr_last_ff) begin
               state_in = pend_ff ? S_FINISH : S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               item_in  = pop_item;
               rphys_in = rphys_calc;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rect_in  = 1'b0;
            full_in  = 1'b0;
            state_in = S_FINISH;
            mulx_in  = 16'(col_ff) * 16'(cfg.char_width);
            muly_in  = 16'(line_ff) * 16'(cfg.char_height);
            case (item_ff.kind)
               K_READ: begin
               end
               K_BACK: begin
                  if (col_ff != '0) begin
                     col_in    = col_dec;
                     mem_we    = 1'b1;
                     mem_waddr = base_ff + AW'(col_dec);
                     mem_wdata = CH_BLANK;
                     rect_in   = 1'b1;
                     mulx_in   = 16'(col_dec) * 16'(cfg.char_width);
                  end
               end
               K_NEWLINE: begin
                  nl = 1'b1;
               end
               K_PRINT: begin
                  mem_we  = 1'b1;
                  rect_in = 1'b1;
                  if (col_ff != CW'(COLS - 1)) begin
                     col_in = col_ff + CW'(1);
                  end else begin
                     nl = 1'b1;
                  end
               end
            endcase
            if (nl) begin
               // the cursor's physical row advances whether or not we scroll
               col_in  = '0;
               phys_in = (phys_ff == RW'(ROWS - 1)) ? '0 : phys_ff + RW'(1);
               base_in = base_next;
               if (line_ff != RW'(ROWS - 1)) begin
                  line_in = line_ff + RW'(1);
               end else begin
                  top_in      = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + RW'(1);
                  full_in     = 1'b1;
                  clr_addr_in = base_next;
                  clr_last_in = base_next + AW'(COLS - 1);
                  pend_in     = 1'b1;
                  state_in    = S_CLEAR;
               end
            end
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_in       = result_now;
               pend_in      = 1'b0;
               pop_ready    = 1'b1;
               if (pop_valid) begin
                  item_in  = pop_item;
                  rphys_in = rphys_calc;
                  state_in = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         col_ff       <= '0;
         line_ff      <= '0;
         top_ff       <= '0;
         phys_ff      <= '0;
         base_ff      <= '0;
         clr_addr_ff  <= '0;
         clr_last_ff  <= AW'(TOTAL - 1);
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         top_ff       <= top_in;
         phys_ff      <= phys_in;
         base_ff      <= base_in;
         clr_addr_ff  <= clr_addr_in;
         clr_last_ff  <= clr_last_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff  <= item_in;
      rphys_ff <= rphys_in;
      mulx_ff  <= mulx_in;
      muly_ff  <= muly_in;
      rect_ff  <= rect_in;
      full_ff  <= full_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

endmodule

`default_nettype wire

FILE: rtl/ttcw_checker.sv
// Port-level checks on the result channel of the terminal writer, and bind.
// Depends on text_terminal_char_writer_assert.svh and the top level.
`default_nettype none

module ttcw_checker #(
   parameter int ROWS = 24
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [87:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

`include "text_terminal_char_writer_assert.svh"

   `TTCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result beat dropped while stalled")
   `TTCW_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result beat changed while stalled")
   `TTCW_ASSERT_NOW(a_scroll_cursor, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata[70:64] == 7'd0 && rsp_tdata[75:71] == 5'(ROWS - 1), "scroll left cursor off bottom row start")
   `TTCW_ASSERT_NOW(a_no_rect_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[63:0] == 64'd0, "rectangle edges set without rect_valid")
   `TTCW_ASSERT_NOW(a_read_quiet, clock, reset, rsp_tvalid && rsp_tdata[83:76] != 8'd0, rsp_tuser == 2'b00, "cell content on a write result")

endmodule

bind text_terminal_char_writer ttcw_checker #(.ROWS(ROWS)) u_ttcw_checker (.*);

`default_nettype wire

FILE: test/text_terminal_char_writer_tb.sv
// Self-checking bench for the character-cell terminal writer: streams text,
// control bytes and cell reads, and checks each result beat against a shadow screen.
// Depends on ttcw_pkg and text_terminal_char_writer.
`timescale 1ns / 1ps

module text_terminal_char_writer_tb
   import ttcw_pkg::*;
();

   localparam int COLS       = 80;
   localparam int ROWS       = 24;
   // Longest quiet stretch is the post-reset sweep of the store; allow plenty more.
   localparam int STALL_LIMIT = 8000;

   // One request beat as the bench sees it, before packing onto the stream.
   typedef struct packed {
      bit       cmd;   // 1: read a cell
      bit [7:0] ch;
      bit [6:0] col;
      bit [4:0] row;
      bit       eob;
   } term_beat_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              req_tuser  = 1'b0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              rsp_tlast;
   logic              csr_we     = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [CSR_DW-1:0] csr_wdata  = '0;

   // Shadow of the terminal: screen contents, cursor, rotation and settings.
   logic [7:0]  screen_mirror [COLS*ROWS];
   int unsigned cur_col  = 0;
   int unsigned cur_row  = 0;
   int unsigned top_base = 0;
   bit [7:0]    cfg_char_w = 8'd8;
   bit [7:0]    cfg_char_h = 8'd16;
   bit [11:0]   cfg_x_off  = '0;
   bit [11:0]   cfg_y_off  = '0;

   // Results still owed by the block, oldest first.
   result_type expected_updates [$];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int errors          = 0;
   int beats_sent      = 0;
   int results_checked = 0;
   int scrolls         = 0;
   int wraps           = 0;
   int quiet_cycles    = 0;

   text_terminal_char_writer #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < COLS*ROWS; i++) screen_mirror[i] = CH_BLANK;
   end

   // ---------------------------------------------------------------------
   // Shadow screen
   // ---------------------------------------------------------------------

   // Visible rows rotate through the store; top_base is the physical top row.
   function automatic int unsigned cell_addr(int unsigned col, int unsigned row);
      return ((top_base + row) % ROWS) * COLS + col;
   endfunction

   // Pixel edges of one cell, packed {bottom, top, right, left}; wraps to 16 bit.
   function automatic logic [63:0] cell_rect(int unsigned col, int unsigned row);
      bit [31:0] left;
      bit [31:0] top;
      left = col * cfg_char_w - cfg_x_off;
      top  = row * cfg_char_h - cfg_y_off;
      return {16'(top + cfg_char_h), 16'(top), 16'(left + cfg_char_w), 16'(left)};
   endfunction

   // Column 0 of the next row; on the last row scroll up and blank the new bottom row.
   function automatic bit next_line();
      cur_col = 0;
      if (cur_row + 1 < ROWS) begin
         cur_row++;
         return 1'b0;
      end
      top_base = (top_base + 1) % ROWS;
      for (int c = 0; c < COLS; c++) screen_mirror[cell_addr(c, ROWS-1)] = CH_BLANK;
      scrolls++;
      return 1'b1;
   endfunction

   // Advance the shadow by one accepted beat and return the result it owes.
   function automatic result_type terminal_apply(term_beat_type b);
      result_type res;
      res = '0;
      if (b.cmd) begin
         // Out-of-range reads come back as zero.
         if (b.col < COLS && b.row < ROWS) res.read_char = screen_mirror[cell_addr(b.col, b.row)];
      end else if (b.ch == CH_BS) begin
         // Backspace at column 0 is dropped; only the cursor is reported.
         if (cur_col > 0) begin
            cur_col--;
            screen_mirror[cell_addr(cur_col, cur_row)] = CH_BLANK;
            res.rect_valid = 1'b1;
            {res.rect_bottom, res.rect_top, res.rect_right, res.rect_left} =
               cell_rect(cur_col, cur_row);
         end
      end else if (b.ch == CH_CR || b.ch == CH_LF) begin
         res.full_redraw = next_line();
      end else begin
         screen_mirror[cell_addr(cur_col, cur_row)] = b.ch;
         res.rect_valid = 1'b1;
         {res.rect_bottom, res.rect_top, res.rect_right, res.rect_left} =
            cell_rect(cur_col, cur_row);
         if (cur_col + 1 < COLS) begin
            cur_col++;
         end else begin
            // Last column: wrap as a new line, possibly scrolling as well.
            wraps++;
            res.full_redraw = next_line();
         end
      end
      res.cursor_col  = 7'(cur_col);
      res.cursor_row  = 5'(cur_row);
      res.buffer_done = b.eob;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   function automatic term_beat_type make_beat(bit cmd, bit [7:0] ch, bit [6:0] col,
                                               bit [4:0] row, bit eob);
      term_beat_type b;
      b.cmd = cmd;
      b.ch  = ch;
      b.col = col;
      b.row = row;
      b.eob = eob;
      return b;
   endfunction

   // Drive one beat, hold it until taken, then record what it should produce.
   // Valid stays high after the handshake; the next beat or an idle gap decides.
   task automatic send_beat(input term_beat_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.cmd;
      req_tlast  <= b.eob;
      req_tdata  <= {4'b0, b.row, b.col, b.ch};
      do @(posedge clock); while (!req_tready);
      expected_updates.push_back(terminal_apply(b));
      beats_sent++;
   endtask

   // Between tests settings change only while the block is idle: wait out the
   // queue, then a further margin; any bottom-row blanking ends before its result is taken.
   task automatic drain_pipeline();
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (COLS + 16) @(posedge clock);
   endtask

   // Write all four settings back to back; enable is held across the burst.
   task automatic write_settings(input bit [7:0] w, input bit [7:0] h,
                                 input bit [11:0] xs, input bit [11:0] ys);
      csr_we    <= 1'b1;
      csr_addr  <= REG_CHAR_WIDTH;
      csr_wdata <= CSR_DW'(w);
      @(posedge clock);
      csr_addr  <= REG_CHAR_HEIGHT;
      csr_wdata <= CSR_DW'(h);
      @(posedge clock);
      csr_addr  <= REG_X_SCROLL;
      csr_wdata <= xs;
      @(posedge clock);
      csr_addr  <= REG_Y_SCROLL;
      csr_wdata <= ys;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_char_w = w;
      cfg_char_h = h;
      cfg_x_off  = xs;
      cfg_y_off  = ys;
   endtask

   // Mostly printable text, with some backspaces and arbitrary bytes mixed in.
   function automatic term_beat_type text_beat();
      int       pick;
      bit [7:0] ch;
      pick = $urandom_range(99);
      if (pick < 8)       ch = CH_BS;
      else if (pick < 14) ch = 8'($urandom_range(0, 255));
      else                ch = 8'($urandom_range(8'h20, 8'h7E));
      return make_beat(1'b0, ch, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                       $urandom_range(7) == 0);
   endfunction

   // Cell reads, mostly inside the visible screen.
   function automatic term_beat_type read_beat();
      bit [6:0] col;
      bit [4:0] row;
      if ($urandom_range(99) < 85) begin
         col = 7'($urandom_range(0, COLS-1));
         row = 5'($urandom_range(0, ROWS-1));
      end else begin
         col = 7'($urandom_range(0, 127));
         row = 5'($urandom_range(0, 31));
      end
      return make_beat(1'b1, 8'($urandom_range(0, 255)), col, row, $urandom_range(7) == 0);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Hand-picked beats: field extremes, every byte class, reads in and out of range.
   task automatic test_directed_cases();
      send_beat(make_beat(1'b1, 8'h00, 7'd0,      5'd0,      1'b0)); // fresh screen is blank
      send_beat(make_beat(1'b1, 8'hFF, 7'd127,    5'd31,     1'b1)); // read far out of range
      send_beat(make_beat(1'b1, 8'h00, 7'(COLS),  5'd0,      1'b0)); // column just past edge
      send_beat(make_beat(1'b1, 8'h00, 7'd0,      5'(ROWS),  1'b0)); // row just past edge
      send_beat(make_beat(1'b1, 8'h00, 7'(COLS-1), 5'(ROWS-1), 1'b0)); // last visible cell
      send_beat(make_beat(1'b0, CH_BS, 7'd0,      5'd0,      1'b0)); // backspace at column 0
      send_beat(make_beat(1'b0, 8'h00, 7'd127,    5'd31,     1'b0)); // NUL is stored
      send_beat(make_beat(1'b0, 8'hFF, 7'd0,      5'd0,      1'b0));
      send_beat(make_beat(1'b0, 8'h41, 7'd0,      5'd0,      1'b1));
      send_beat(make_beat(1'b0, CH_BS, 7'd0,      5'd0,      1'b0)); // blank the 'A'
      send_beat(make_beat(1'b1, 8'h00, 7'd2,      5'd0,      1'b0));
      send_beat(make_beat(1'b1, 8'h00, 7'd1,      5'd0,      1'b0));
      send_beat(make_beat(1'b1, 8'h00, 7'd0,      5'd0,      1'b0));
      send_beat(make_beat(1'b0, CH_CR, 7'd0,      5'd0,      1'b0));
      send_beat(make_beat(1'b0, CH_LF, 7'd0,      5'd0,      1'b1));
      send_beat(make_beat(1'b0, 8'h7F, 7'd0,      5'd0,      1'b0));
      send_beat(make_beat(1'b0, 8'h09, 7'd0,      5'd0,      1'b0)); // tab is just a glyph
      send_beat(make_beat(1'b0, CH_BLANK, 7'd0,   5'd0,      1'b0));
      send_beat(make_beat(1'b1, 8'h00, 7'd0,      5'd2,      1'b0));
      send_beat(make_beat(1'b1, 8'h00, 7'd1,      5'd2,      1'b1));
      send_beat(make_beat(1'b0, CH_BS, 7'd0,      5'd0,      1'b0));
      send_beat(make_beat(1'b0, CH_LF, 7'd0,      5'd0,      1'b0));
      req_tvalid <= 1'b0;
   endtask

   // Lines of text ending in CR or LF. Some lines run to or past the last
   // column to force wraps; enough lines to reach the bottom and scroll.
   task automatic test_text_stream(input int n_beats);
      int pick;
      int line_len;
      int sent;
      sent = 0;
      while (sent < n_beats) begin
         pick = $urandom_range(99);
         if (pick < 70)      line_len = $urandom_range(0, 8);
         else if (pick < 90) line_len = $urandom_range(60, 85);
         else                line_len = $urandom_range(COLS-1, COLS+1);
         for (int k = 0; k < line_len && sent < n_beats; k++) begin
            if ($urandom_range(99) < 15) begin
               send_beat(read_beat());
               sent++;
            end
            send_beat(text_beat());
            sent++;
         end
         if (sent < n_beats) begin
            send_beat(make_beat(1'b0, $urandom_range(1) ? CH_CR : CH_LF,
                                7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                                $urandom_range(3) == 0));
            sent++;
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         errors++;
      end
   endtask

   // Compare one result beat, field by field, with the oldest pending update.
   task automatic check_result();
      result_type exp_res;
      if (expected_updates.size() == 0) begin
         $error("result beat arrived with no update pending");
         errors++;
         return;
      end
      exp_res = expected_updates.pop_front();
      check_field("rect_valid",  exp_res.rect_valid,  rsp_tuser[0]);
      check_field("full_redraw", exp_res.full_redraw, rsp_tuser[1]);
      check_field("rect_left",   exp_res.rect_left,   rsp_tdata[15:0]);
      check_field("rect_right",  exp_res.rect_right,  rsp_tdata[31:16]);
      check_field("rect_top",    exp_res.rect_top,    rsp_tdata[47:32]);
      check_field("rect_bottom", exp_res.rect_bottom, rsp_tdata[63:48]);
      check_field("cursor_col",  exp_res.cursor_col,  rsp_tdata[70:64]);
      check_field("cursor_row",  exp_res.cursor_row,  rsp_tdata[75:71]);
      check_field("read_char",   exp_res.read_char,   rsp_tdata[83:76]);
      check_field("buffer_done", exp_res.buffer_done, rsp_tlast);
      results_checked++;
   endtask

   // Sample the handshake as it stood at the edge, then pick the next ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: count edges with no beat moving on either stream.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d updates pending",
                     quiet_cycles, expected_updates.size());
            $display("text_terminal_char_writer_tb: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings written explicitly; the store sweep runs meanwhile.
      write_settings(8'd8, 8'd16, 12'd0, 12'd0);
      send_idle_pct = 37;
      recv_idle_pct = 69;
      test_directed_cases();

      // Largest cells and offsets: edges go negative and wrap.
      drain_pipeline();
      write_settings(8'd255, 8'd255, 12'd4095, 12'd4095);
      test_text_stream(370);

      // Smallest cells, idling swapped between the two sides.
      drain_pipeline();
      send_idle_pct = 69;
      recv_idle_pct = 37;
      write_settings(8'd1, 8'd1, 12'd0, 12'd0);
      test_text_stream(370);

      // Full rate on both sides: random settings, then a mixed extreme.
      drain_pipeline();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      test_text_stream(180);
      drain_pipeline();
      write_settings(8'd1, 8'd255, 12'd4095, 12'd0);
      test_text_stream(180);

      drain_pipeline();
      $display("covered %0d request beats, %0d results checked", beats_sent, results_checked);
      $display("screen scrolled %0d times, %0d wraps at the last column", scrolls, wraps);
      if (errors == 0) begin
         $display("text_terminal_char_writer_tb: PASS");
      end else begin
         $display("text_terminal_char_writer_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: text_terminal_char_writer.f
+incdir+rtl
rtl/ttcw_pkg.sv
rtl/ttcw_front.sv
rtl/ttcw_fifo.sv
rtl/ttcw_back.sv
rtl/text_terminal_char_writer.sv
rtl/ttcw_checker.sv
test/text_terminal_char_writer_tb.sv
